[rtl/bcim_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcim_pkg
// Shared widths, operation codes and register indexes for the index mapper.
// ----------------------------------------------------------------------------
package bcim_pkg;

  // default field widths
  localparam int unsigned IndexBitsDef = 20;
  localparam int unsigned PartBitsDef  = 10;

  // operation codes carried by func
  typedef enum logic [2:0] {
    FN_BLK_FWD   = 3'd0,
    FN_BLK_INV   = 3'd1,
    FN_PART_SIZE = 3'd2,
    FN_CYC_FWD   = 3'd3,
    FN_CYC_INV   = 3'd4
  } func_e;

  // register indexes on the config port
  localparam logic RegNumParts = 1'b0;
  localparam logic RegTotal    = 1'b1;

endpackage

[rtl/bcim_cfg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcim_cfg
// Config registers on the apb port, plus a sequencer that derives the block
// layout (entries per partition, remainder, size of the larger partitions).
// ----------------------------------------------------------------------------
module bcim_cfg
  import bcim_pkg::*;
#(
  parameter int unsigned IndexBits = IndexBitsDef,
  parameter int unsigned PartBits  = PartBitsDef,
  parameter int unsigned DataW     = 32,
  parameter int unsigned AddrW     = 3
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [AddrW-1:0]     paddr,
  input  logic [DataW-1:0]     pwdata,
  output logic [DataW-1:0]     prdata,
  output logic                 pready,
  output logic                 busy_o,
  output logic                 bad_o,
  output logic [PartBits:0]    np_o,
  output logic [IndexBits:0]   n_o,
  output logic [IndexBits:0]   l_o,
  output logic [IndexBits:0]   l1_o,
  output logic [PartBits:0]    r_o,
  output logic [IndexBits:0]   b_o
);

  localparam int unsigned CntW = $clog2(IndexBits + 2);

  typedef enum logic [3:0] {
    CS_IDLE = 4'b0001,
    CS_LOAD = 4'b0010,
    CS_DIV  = 4'b0100,
    CS_MUL  = 4'b1000
  } cfg_state_e;

  cfg_state_e state_q, state_d;
  logic [PartBits:0]   np_q;
  logic [IndexBits:0]  n_q;
  logic [IndexBits:0]  dvd_q, quo_q;
  logic [PartBits+1:0] rem_q;
  logic [CntW-1:0]     cnt_q;
  logic [IndexBits:0]  l_q, l1_q, b_q;
  logic [PartBits:0]   r_q;
  logic                wr_en;
  logic [PartBits+1:0] trial;
  logic                trial_ge;
  logic [IndexBits+PartBits+2:0] prod;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite & pready;

  // register readback
  always_comb begin
    case (paddr[AddrW-1])
      RegNumParts: prdata = DataW'(np_q);
      RegTotal:    prdata = DataW'(n_q);
      default:     prdata = '0;
    endcase
  end

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      np_q <= (PartBits+1)'(1);
      n_q  <= (IndexBits+1)'(1);
    end else if (wr_en) begin
      if (paddr[AddrW-1] == RegNumParts) begin
        np_q <= pwdata[PartBits:0];
      end else begin
        n_q <= pwdata[IndexBits:0];
      end
    end
  end

  // one restoring division step per cycle
  assign trial    = {rem_q[PartBits:0], dvd_q[IndexBits]};
  assign trial_ge = trial >= {1'b0, np_q};
  assign prod     = (IndexBits+PartBits+3)'(l1_q * r_q);

  // any write restarts the sequencer with the new register values
  always_comb begin
    state_d = state_q;
    case (state_q)
      CS_IDLE: if (wr_en) state_d = CS_LOAD;
      CS_LOAD: state_d = CS_DIV;
      CS_DIV:  if (cnt_q == CntW'(IndexBits)) state_d = CS_MUL;
      CS_MUL:  state_d = CS_IDLE;
      default: state_d = CS_IDLE;
    endcase
    if (wr_en) state_d = CS_LOAD;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= CS_IDLE;
      cnt_q   <= '0;
      l_q     <= (IndexBits+1)'(1);
      l1_q    <= (IndexBits+1)'(2);
      r_q     <= '0;
      b_q     <= '0;
    end else begin
      state_q <= state_d;
      case (state_q)
        CS_LOAD: cnt_q <= '0;
        CS_DIV:  cnt_q <= cnt_q + CntW'(1);
        CS_MUL: begin
          l_q  <= quo_q;
          l1_q <= quo_q + (IndexBits+1)'(1);
          r_q  <= rem_q[PartBits:0];
        end
        default: ;
      endcase
      if (state_q == CS_IDLE && l1_q != '0) begin
        b_q <= prod[IndexBits:0];
      end
    end
  end

  // divider datapath
  always_ff @(posedge clk_i) begin
    if (state_q == CS_LOAD) begin
      dvd_q <= n_q;
      quo_q <= '0;
      rem_q <= '0;
    end else if (state_q == CS_DIV) begin
      dvd_q <= {dvd_q[IndexBits-1:0], 1'b0};
      quo_q <= {quo_q[IndexBits-1:0], trial_ge};
      rem_q <= trial_ge ? (trial - {1'b0, np_q}) : trial;
    end
  end

  // the product is refreshed while idle, using the latched layout
  assign busy_o = (state_q != CS_IDLE);
  assign bad_o  = (np_q == '0) || (np_q > {1'b1, {PartBits{1'b0}}}) ||
                  (n_q == '0) || (n_q > {1'b1, {IndexBits{1'b0}}});
  assign np_o   = np_q;
  assign n_o    = n_q;
  assign l_o    = l_q;
  assign l1_o   = l1_q;
  assign r_o    = r_q;
  assign b_o    = b_q;

endmodule

[rtl/bcim_prep.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcim_prep
// Two stages ahead of the divider: range checks, operand selection and the
// multiply for the inverse mappings, then the final add and bound check.
// ----------------------------------------------------------------------------
module bcim_prep
  import bcim_pkg::*;
#(
  parameter int unsigned IndexBits = IndexBitsDef,
  parameter int unsigned PartBits  = PartBitsDef
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 vld_i,
  input  logic [2:0]           func_i,
  input  logic [IndexBits-1:0] gi_i,
  input  logic [PartBits-1:0]  p_i,
  input  logic [IndexBits-1:0] li_i,
  input  logic                 bad_i,
  input  logic [PartBits:0]    np_i,
  input  logic [IndexBits:0]   n_i,
  input  logic [IndexBits:0]   l_i,
  input  logic [IndexBits:0]   l1_i,
  input  logic [PartBits:0]    r_i,
  input  logic [IndexBits:0]   b_i,
  output logic                 vld_o,
  output logic [2:0]           func_o,
  output logic                 err_o,
  output logic [IndexBits-1:0] num_o,
  output logic [IndexBits:0]   den_o,
  output logic [PartBits-1:0]  qadd_o,
  output logic [IndexBits-1:0] rx_o,
  output logic [IndexBits:0]   size_o
);

  localparam int unsigned ProdW = IndexBits + PartBits + 2;

  logic gi_ge_n, p_ge_np, p_lt_r, blk_lo;
  logic [IndexBits:0] size;
  logic err_b;
  logic [IndexBits-1:0] num_b;
  logic [IndexBits:0]   den_b;
  logic [PartBits-1:0]  qadd_b;
  logic [IndexBits:0]   ma;
  logic [PartBits:0]    mb;
  logic [IndexBits:0]   base_b;

  logic                 b_vld_q;
  logic [2:0]           b_func_q;
  logic                 b_err_q;
  logic [IndexBits-1:0] b_num_q;
  logic [IndexBits:0]   b_den_q;
  logic [PartBits-1:0]  b_qadd_q;
  logic [ProdW-1:0]     b_prod_q;
  logic [IndexBits:0]   b_base_q;
  logic [IndexBits:0]   b_size_q;

  logic [ProdW-1:0]     sum;

  logic                 c_vld_q;
  logic [2:0]           c_func_q;
  logic                 c_err_q;
  logic [IndexBits-1:0] c_num_q;
  logic [IndexBits:0]   c_den_q;
  logic [PartBits-1:0]  c_qadd_q;
  logic [IndexBits-1:0] c_rx_q;
  logic [IndexBits:0]   c_size_q;

  // range checks
  assign gi_ge_n = {1'b0, gi_i} >= n_i;
  assign p_ge_np = {1'b0, p_i} >= np_i;
  assign p_lt_r  = {1'b0, p_i} < r_i;
  assign blk_lo  = {1'b0, gi_i} < b_i;
  assign size    = p_lt_r ? l1_i : l_i;

  // per-operation error and operand selection
  always_comb begin
    err_b  = 1'b1;
    num_b  = gi_i;
    den_b  = {{(IndexBits-PartBits){1'b0}}, np_i};
    qadd_b = '0;
    ma     = {1'b0, li_i};
    mb     = np_i;
    base_b = (IndexBits+1)'(p_i);
    case (func_i)
      FN_BLK_FWD: begin
        err_b = gi_ge_n;
        if (blk_lo) begin
          den_b = l1_i;
        end else begin
          num_b  = gi_i - b_i[IndexBits-1:0];
          den_b  = l_i;
          qadd_b = r_i[PartBits-1:0];
        end
      end
      FN_BLK_INV: begin
        err_b = p_ge_np || ({1'b0, li_i} >= size);
        if (p_lt_r) begin
          ma     = l1_i;
          mb     = {1'b0, p_i};
          base_b = {1'b0, li_i};
        end else begin
          ma     = l_i;
          mb     = {1'b0, p_i} - r_i;
          base_b = {1'b0, li_i} + b_i;
        end
      end
      FN_PART_SIZE: err_b = p_ge_np;
      FN_CYC_FWD:   err_b = gi_ge_n;
      FN_CYC_INV:   err_b = p_ge_np;
      default:      err_b = 1'b1;
    endcase
    err_b = err_b | bad_i;
  end

  // stage b, with the valid bits of both stages
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_vld_q <= 1'b0;
      c_vld_q <= 1'b0;
    end else begin
      b_vld_q <= vld_i;
      c_vld_q <= b_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    b_func_q <= func_i;
    b_err_q  <= err_b;
    b_num_q  <= num_b;
    b_den_q  <= den_b;
    b_qadd_q <= qadd_b;
    b_prod_q <= ProdW'(ma * mb);
    b_base_q <= base_b;
    b_size_q <= size;
  end

  // stage c: inverse index and its bound
  assign sum = b_prod_q + ProdW'(b_base_q);

  always_ff @(posedge clk_i) begin
    c_func_q <= b_func_q;
    c_err_q  <= b_err_q ||
                (b_func_q == FN_CYC_INV && sum >= ProdW'(n_i));
    c_num_q  <= b_num_q;
    c_den_q  <= b_den_q;
    c_qadd_q <= b_qadd_q;
    c_rx_q   <= sum[IndexBits-1:0];
    c_size_q <= b_size_q;
  end

  assign vld_o  = c_vld_q;
  assign func_o = c_func_q;
  assign err_o  = c_err_q;
  assign num_o  = c_num_q;
  assign den_o  = c_den_q;
  assign qadd_o = c_qadd_q;
  assign rx_o   = c_rx_q;
  assign size_o = c_size_q;

endmodule

[rtl/bcim_div.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcim_div
// Pipelined restoring divider, one quotient bit per stage, with a sideband
// word that travels alongside each item.
// ----------------------------------------------------------------------------
module bcim_div
  import bcim_pkg::*;
#(
  parameter int unsigned NumW = IndexBitsDef,
  parameter int unsigned DenW = IndexBitsDef + 1,
  parameter int unsigned SbW  = 8
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            vld_i,
  input  logic [NumW-1:0] num_i,
  input  logic [DenW-1:0] den_i,
  input  logic [SbW-1:0]  sb_i,
  output logic            vld_o,
  output logic [NumW-1:0] quo_o,
  output logic [DenW-1:0] rem_o,
  output logic [SbW-1:0]  sb_o
);

  logic            vld_q [NumW];
  logic [NumW-1:0] num_q [NumW];
  logic [NumW-1:0] quo_q [NumW];
  logic [DenW-1:0] rem_q [NumW];
  logic [DenW-1:0] den_q [NumW];
  logic [SbW-1:0]  sb_q  [NumW];

  for (genvar s = 0; s < NumW; s++) begin : g_stage
    logic            vld_in;
    logic [NumW-1:0] num_in, quo_in;
    logic [DenW-1:0] rem_in, den_in;
    logic [SbW-1:0]  sb_in;
    logic [DenW:0]   trial;
    logic            ge;

    if (s == 0) begin : g_first
      assign vld_in = vld_i;
      assign num_in = num_i;
      assign quo_in = '0;
      assign rem_in = '0;
      assign den_in = den_i;
      assign sb_in  = sb_i;
    end else begin : g_next
      assign vld_in = vld_q[s-1];
      assign num_in = num_q[s-1];
      assign quo_in = quo_q[s-1];
      assign rem_in = rem_q[s-1];
      assign den_in = den_q[s-1];
      assign sb_in  = sb_q[s-1];
    end

    // bring down the next dividend bit and try a subtract
    assign trial = {rem_in, num_in[NumW-1]};
    assign ge    = trial >= {1'b0, den_in};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s] <= 1'b0;
      end else begin
        vld_q[s] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      num_q[s] <= num_in << 1;
      quo_q[s] <= {quo_in[NumW-2:0], ge};
      rem_q[s] <= ge ? DenW'(trial - {1'b0, den_in}) : trial[DenW-1:0];
      den_q[s] <= den_in;
      sb_q[s]  <= sb_in;
    end
  end

  assign vld_o = vld_q[NumW-1];
  assign quo_o = quo_q[NumW-1];
  assign rem_o = rem_q[NumW-1];
  assign sb_o  = sb_q[NumW-1];

endmodule

[rtl/block_cyclic_index_mapping.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// block_cyclic_index_mapping
// Index mapper for block and cyclic distribution of an array over partitions.
// ----------------------------------------------------------------------------
// Usage:
//   The partition count and the total entry count are written over the apb
//   port. Each write starts a layout sequencer (one restoring division step
//   per cycle, then a multiply); a later write restarts it. busy is high
//   while it runs and no item is taken.
//   An item (func, index, part, offset) is taken at a clock edge with start
//   high and busy low. While busy is low items may follow every cycle:
//   throughput is one item per clock, set by the pipelined divider with
//   one stage per index bit. Each item gives exactly one result, shown for
//   one cycle with done high, after the prep, divider and output registers.
//   The receiver cannot stall, so results leave in order with no backpressure.
//   Reset restores one partition and one entry and empties the pipeline.
// ----------------------------------------------------------------------------
module block_cyclic_index_mapping
  import bcim_pkg::*;
#(
  parameter int unsigned IndexBits = IndexBitsDef,
  parameter int unsigned PartBits  = PartBitsDef,
  localparam int unsigned DataW    = (IndexBits + 1 > 32) ? 64 : 32,
  localparam int unsigned AddrW    = (DataW == 64) ? 4 : 3
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [AddrW-1:0]     paddr,
  input  logic [DataW-1:0]     pwdata,
  output logic [DataW-1:0]     prdata,
  output logic                 pready,
  input  logic                 start,
  output logic                 busy,
  input  logic [2:0]           func_i,
  input  logic [IndexBits-1:0] index_i,
  input  logic [PartBits-1:0]  part_i,
  input  logic [IndexBits-1:0] offset_i,
  output logic                 done_o,
  output logic [PartBits-1:0]  out_part_o,
  output logic [IndexBits-1:0] out_offset_o,
  output logic [IndexBits-1:0] out_index_o,
  output logic [IndexBits:0]   part_size_o,
  output logic                 error_o
);

  localparam int unsigned SbW = 3 + 1 + PartBits + IndexBits + IndexBits + 1;

  logic                 bad;
  logic [PartBits:0]    np, r;
  logic [IndexBits:0]   n, l, l1, b;

  logic                 a_vld_q;
  logic [2:0]           a_func_q;
  logic [IndexBits-1:0] a_gi_q, a_li_q;
  logic [PartBits-1:0]  a_p_q;

  logic                 c_vld;
  logic [2:0]           c_func;
  logic                 c_err;
  logic [IndexBits-1:0] c_num, c_rx;
  logic [IndexBits:0]   c_den, c_size;
  logic [PartBits-1:0]  c_qadd;

  logic                 d_vld;
  logic [IndexBits-1:0] d_quo;
  logic [IndexBits:0]   d_rem;
  logic [SbW-1:0]       d_sb;
  logic [2:0]           d_func;
  logic                 d_err;
  logic [PartBits-1:0]  d_qadd;
  logic [IndexBits-1:0] d_rx;
  logic [IndexBits:0]   d_size;

  logic                 done_q, err_q;
  logic [PartBits-1:0]  part_d, part_q;
  logic [IndexBits-1:0] offs_d, offs_q, idx_d, idx_q;
  logic [IndexBits:0]   size_d, size_q;

  bcim_cfg #(
    .IndexBits(IndexBits),
    .PartBits (PartBits),
    .DataW    (DataW),
    .AddrW    (AddrW)
  ) u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready),
    .busy_o (busy),
    .bad_o  (bad),
    .np_o   (np),
    .n_o    (n),
    .l_o    (l),
    .l1_o   (l1),
    .r_o    (r),
    .b_o    (b)
  );

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
    end else begin
      a_vld_q <= start & ~busy;
    end
  end

  always_ff @(posedge clk_i) begin
    a_func_q <= func_i;
    a_gi_q   <= index_i;
    a_p_q    <= part_i;
    a_li_q   <= offset_i;
  end

  bcim_prep #(
    .IndexBits(IndexBits),
    .PartBits (PartBits)
  ) u_prep (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .vld_i (a_vld_q),
    .func_i(a_func_q),
    .gi_i  (a_gi_q),
    .p_i   (a_p_q),
    .li_i  (a_li_q),
    .bad_i (bad),
    .np_i  (np),
    .n_i   (n),
    .l_i   (l),
    .l1_i  (l1),
    .r_i   (r),
    .b_i   (b),
    .vld_o (c_vld),
    .func_o(c_func),
    .err_o (c_err),
    .num_o (c_num),
    .den_o (c_den),
    .qadd_o(c_qadd),
    .rx_o  (c_rx),
    .size_o(c_size)
  );

  bcim_div #(
    .NumW(IndexBits),
    .DenW(IndexBits + 1),
    .SbW (SbW)
  ) u_div (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .vld_i (c_vld),
    .num_i (c_num),
    .den_i (c_den),
    .sb_i  ({c_func, c_err, c_qadd, c_rx, c_size}),
    .vld_o (d_vld),
    .quo_o (d_quo),
    .rem_o (d_rem),
    .sb_o  (d_sb)
  );

  assign {d_func, d_err, d_qadd, d_rx, d_size} = d_sb;

  // result select, zeroed on error
  always_comb begin
    part_d = '0;
    offs_d = '0;
    idx_d  = '0;
    size_d = '0;
    case (d_func)
      FN_BLK_FWD: begin
        part_d = d_qadd + d_quo[PartBits-1:0];
        offs_d = d_rem[IndexBits-1:0];
      end
      FN_BLK_INV:   idx_d  = d_rx;
      FN_PART_SIZE: size_d = d_size;
      FN_CYC_FWD: begin
        part_d = d_rem[PartBits-1:0];
        offs_d = d_quo;
      end
      FN_CYC_INV:   idx_d  = d_rx;
      default: ;
    endcase
    if (d_err) begin
      part_d = '0;
      offs_d = '0;
      idx_d  = '0;
      size_d = '0;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= d_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    part_q <= part_d;
    offs_q <= offs_d;
    idx_q  <= idx_d;
    size_q <= size_d;
    err_q  <= d_err;
  end

  assign done_o       = done_q;
  assign out_part_o   = part_q;
  assign out_offset_o = offs_q;
  assign out_index_o  = idx_q;
  assign part_size_o  = size_q;
  assign error_o      = err_q;

endmodule

[test/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the block/cyclic index mapper. Phases of items run
// under different partition layouts, including bad ones, while the item
// sender idles at varying rates. Each item's expected mapping is computed
// here and compared field by field with the result that comes back.
// ----------------------------------------------------------------------------
module tb_top;
  import bcim_pkg::*;

  localparam int unsigned IdxW = IndexBitsDef;
  localparam int unsigned PrtW = PartBitsDef;
  localparam int unsigned DrainCycles = IdxW + 10;
  localparam int unsigned WatchdogLimit = 5000;
  localparam int unsigned ItemsPerPhase = 65;
  localparam logic [2:0] FnFirstUnused = 3'd5;

  typedef struct {
    logic [2:0]      func;
    logic [IdxW-1:0] index;
    logic [PrtW-1:0] part;
    logic [IdxW-1:0] offset;
  } map_req_t;

  typedef struct {
    logic [PrtW-1:0] out_part;
    logic [IdxW-1:0] out_offset;
    logic [IdxW-1:0] out_index;
    logic [IdxW:0]   part_size;
    logic            error;
  } map_res_t;

  logic clk_i, rst_ni;
  logic psel, penable, pwrite, pready;
  logic [2:0] paddr;
  logic [31:0] pwdata, prdata;
  logic start, busy, done_o, error_o;
  logic [2:0] func_i;
  logic [IdxW-1:0] index_i, offset_i, out_offset_o, out_index_o;
  logic [PrtW-1:0] part_i, out_part_o;
  logic [IdxW:0] part_size_o;

  block_cyclic_index_mapping i_dut (.*);

  // clock
  initial clk_i = 1'b0;
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // layout mirror, pending items and expected mappings
  logic [PrtW:0] layout_parts = 1;
  logic [IdxW:0] layout_total = 1;
  map_req_t pending_reqs[$];
  map_res_t expected_maps[$];
  int unsigned idle_pct = 0;
  int unsigned fail_count = 0;
  int unsigned items_done = 0, errors_seen = 0, idle_cycles = 0;

  // expected mapping of one item under the current layout
  function automatic map_res_t compute_mapping(map_req_t rq);
    map_res_t rs;
    longint unsigned np, n, l, r, gi, p, li, sz, g, rest;
    logic err;
    np = layout_parts;
    n = layout_total;
    gi = rq.index;
    p = rq.part;
    li = rq.offset;
    rs = '{default: '0};
    err = 1'b0;
    if (np == 0 || np > (64'd1 << PrtW) || n == 0 || n > (64'd1 << IdxW)) begin
      err = 1'b1;
    end else begin
      l = n / np;
      r = n % np;
      sz = (p < r) ? l + 1 : l;
      case (rq.func)
        FN_BLK_FWD: begin
          if (gi >= n) err = 1'b1;
          else if (gi < (l + 1) * r) begin
            rs.out_part = PrtW'(gi / (l + 1));
            rs.out_offset = IdxW'(gi % (l + 1));
          end else begin
            rest = gi - (l + 1) * r;
            rs.out_part = PrtW'(r + rest / l);
            rs.out_offset = IdxW'(rest % l);
          end
        end
        FN_BLK_INV: begin
          if (p >= np || li >= sz) err = 1'b1;
          else if (p < r) rs.out_index = IdxW'(li + (l + 1) * p);
          else rs.out_index = IdxW'(li + r * (l + 1) + (p - r) * l);
        end
        FN_PART_SIZE: begin
          if (p >= np) err = 1'b1;
          else rs.part_size = (IdxW + 1)'(sz);
        end
        FN_CYC_FWD: begin
          if (gi >= n) err = 1'b1;
          else begin
            rs.out_part = PrtW'(gi % np);
            rs.out_offset = IdxW'(gi / np);
          end
        end
        FN_CYC_INV: begin
          g = li * np + p;
          if (p >= np || g >= n) err = 1'b1;
          else rs.out_index = IdxW'(g);
        end
        default: err = 1'b1;
      endcase
    end
    if (err) rs = '{default: '0};
    rs.error = err;
    return rs;
  endfunction

  // item driver
  always @(posedge clk_i or negedge rst_ni) begin
    map_req_t rq;
    if (!rst_ni) begin
      start <= 1'b0;
      func_i <= '0;
      index_i <= '0;
      part_i <= '0;
      offset_i <= '0;
    end else if (!(start && busy)) begin
      if (start) begin
        rq = '{func_i, index_i, part_i, offset_i};
        expected_maps.push_back(compute_mapping(rq));
      end
      if (pending_reqs.size() > 0 && $urandom_range(99) >= idle_pct) begin
        rq = pending_reqs.pop_front();
        start <= 1'b1;
        func_i <= rq.func;
        index_i <= rq.index;
        part_i <= rq.part;
        offset_i <= rq.offset;
      end else begin
        start <= 1'b0;
        if (pending_reqs.size() > 0) idle_cycles++;
      end
    end
  end

  // result monitor
  always @(posedge clk_i) begin
    map_res_t ex;
    if (rst_ni && done_o) begin
      if (expected_maps.size() == 0) begin
        $error("result with no item outstanding");
        fail_count++;
      end else begin
        ex = expected_maps.pop_front();
        items_done++;
        if (ex.error) errors_seen++;
        if (out_part_o !== ex.out_part) begin
          $error("out_part exp %0d got %0d", ex.out_part, out_part_o);
          fail_count++;
        end
        if (out_offset_o !== ex.out_offset) begin
          $error("out_offset exp %0d got %0d", ex.out_offset, out_offset_o);
          fail_count++;
        end
        if (out_index_o !== ex.out_index) begin
          $error("out_index exp %0d got %0d", ex.out_index, out_index_o);
          fail_count++;
        end
        if (part_size_o !== ex.part_size) begin
          $error("part_size exp %0d got %0d", ex.part_size, part_size_o);
          fail_count++;
        end
        if (error_o !== ex.error) begin
          $error("error exp %0d got %0d", ex.error, error_o);
          fail_count++;
        end
      end
    end
  end

  // watchdog on cycles with no progress
  int unsigned stall_count = 0;
  always @(posedge clk_i) begin
    if ((start && !busy) || done_o || (psel && penable) || !rst_ni) stall_count <= 0;
    else stall_count <= stall_count + 1;
    if (stall_count >= WatchdogLimit) begin
      $display("watchdog expired");
      $display("Regression FAIL");
      $finish;
    end
  end

  task automatic write_reg(input logic reg_idx, input logic [31:0] value);
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {reg_idx, 2'b00};
    pwdata <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (reg_idx == RegNumParts) layout_parts = value[PrtW:0];
    else layout_total = value[IdxW:0];
  endtask

  task automatic set_layout(input logic [31:0] np, input logic [31:0] n);
    write_reg(RegNumParts, np);
    write_reg(RegTotal, n);
    do @(posedge clk_i); while (busy);
  endtask

  task automatic queue_req(input logic [2:0] f, input longint unsigned gi,
                           input longint unsigned p, input longint unsigned li);
    pending_reqs.push_back('{f, IdxW'(gi), PrtW'(p), IdxW'(li)});
  endtask

  // wait for all items to map out, then let the pipeline settle
  task automatic drain();
    do @(posedge clk_i); while (pending_reqs.size() > 0 || start || expected_maps.size() > 0);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // mostly well-formed items for the current layout, some noise
  task automatic queue_random_req();
    longint unsigned np, n, p, sz, kind;
    np = layout_parts;
    n = layout_total;
    kind = $urandom_range(0, 11);
    if (np == 0 || np > (64'd1 << PrtW) || n == 0 || n > (64'd1 << IdxW) || kind >= 10) begin
      queue_req(3'($urandom_range(0, 7)), $urandom, $urandom, $urandom);
    end else if (kind == 9) begin
      queue_req(FnFirstUnused + 3'($urandom_range(0, 2)), $urandom, $urandom, $urandom);
    end else begin
      p = $urandom_range(0, np - 1);
      if ($urandom_range(0, 7) == 0) p = $urandom;
      sz = n / np + ((p < n % np) ? 1 : 0);
      case (kind % 5)
        0, 3: queue_req(3'(kind % 5), ($urandom_range(0, 7) == 0) ?
                          longint'($urandom) : $urandom_range(0, n - 1), $urandom, $urandom);
        1: queue_req(FN_BLK_INV, $urandom, p, ($urandom_range(0, 7) == 0 || sz == 0) ?
                       longint'($urandom) : $urandom_range(0, sz - 1));
        2: queue_req(FN_PART_SIZE, $urandom, p, $urandom);
        default: queue_req(FN_CYC_INV, $urandom, p, ($urandom_range(0, 7) == 0) ?
                             longint'($urandom) : $urandom_range(0, (n - 1) / np));
      endcase
    end
  endtask

  int unsigned layouts_np[] = '{1024, 1, 3, 1024, 1000, 0, 1500, 4, 4, 1};
  int unsigned layouts_n[] = '{1048576, 1048576, 1048576, 5, 999, 10, 10, 0, 2000000, 1};

  // stimulus sequence
  initial begin
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    rst_ni = 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    do @(posedge clk_i); while (busy);

    // directed items at the reset layout, then at 7 parts over 100 entries
    queue_req(FN_BLK_FWD, 0, 0, 0);
    queue_req(FN_CYC_FWD, 1, 0, 0);
    drain();
    set_layout(7, 100);
    queue_req(FN_BLK_FWD, 0, 0, 0);
    queue_req(FN_BLK_FWD, 99, 0, 0);
    queue_req(FN_BLK_FWD, 100, 0, 0);
    queue_req(FN_BLK_FWD, 1048575, 1023, 1048575);
    queue_req(FN_BLK_INV, 0, 0, 0);
    queue_req(FN_BLK_INV, 0, 1, 14);
    queue_req(FN_BLK_INV, 0, 1, 15);
    queue_req(FN_BLK_INV, 0, 6, 13);
    queue_req(FN_BLK_INV, 0, 6, 14);
    queue_req(FN_BLK_INV, 0, 7, 0);
    queue_req(FN_PART_SIZE, 0, 0, 0);
    queue_req(FN_PART_SIZE, 0, 6, 0);
    queue_req(FN_PART_SIZE, 0, 1023, 0);
    queue_req(FN_CYC_FWD, 99, 0, 0);
    queue_req(FN_CYC_FWD, 100, 0, 0);
    queue_req(FN_CYC_INV, 0, 6, 13);
    queue_req(FN_CYC_INV, 0, 2, 14);
    queue_req(FN_CYC_INV, 0, 7, 0);
    queue_req(FN_CYC_INV, 0, 0, 1048575);
    for (int k = 0; k < 3; k++) queue_req(FnFirstUnused + 3'(k), 5, 1, 1);
    drain();

    // random phases over layouts and idle rates
    for (int ph = 0; ph < layouts_np.size(); ph++) begin
      set_layout(layouts_np[ph], layouts_n[ph]);
      case (ph % 4)
        1: idle_pct = 87;
        3: idle_pct = 26;
        default: idle_pct = 0;
      endcase
      for (int i = 0; i < ItemsPerPhase; i++) queue_random_req();
      drain();
    end

    $display("covered %0d items (%0d flagged as errors) over %0d layouts, %0d idle cycles",
             items_done, errors_seen, layouts_np.size() + 2, idle_cycles);
    if (fail_count == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

endmodule

[sim.f]
rtl/bcim_pkg.sv
rtl/bcim_cfg.sv
rtl/bcim_prep.sv
rtl/bcim_div.sv
rtl/block_cyclic_index_mapping.sv
test/tb_top.sv
